// File: rtl/array_deque_with_indexed_read_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the deque block
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ARRAY_DEQUE_WITH_INDEXED_READ_ASSERT_SVH
`define ARRAY_DEQUE_WITH_INDEXED_READ_ASSERT_SVH

// Check that an expression holds at every edge out of reset
`define ADQ_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("deque invariant violated");

// Check that a condition in one cycle implies a consequence in the next
`define ADQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque sequencing violated");

`endif

// File: rtl/adq_pkg.sv
// ----------------------------------------------------------------------------
// adq_pkg
// Defaults, request kinds, status codes and cell control for the deque.
// ----------------------------------------------------------------------------
package adq_pkg;

  // Default sizes
  localparam int unsigned DepthDef    = 64;
  localparam int unsigned WordBitsDef = 32;

  // Request kinds
  localparam logic [2:0] KIND_READ      = 3'd0;
  localparam logic [2:0] KIND_INS_FRONT = 3'd1;
  localparam logic [2:0] KIND_INS_BACK  = 3'd2;
  localparam logic [2:0] KIND_REM_FRONT = 3'd3;
  localparam logic [2:0] KIND_REM_BACK  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Shift and load commands broadcast to every cell
  typedef struct packed {
    logic ins_front;
    logic rem_front;
    logic ins_back;
  } cell_ctl_t;

endpackage

// File: rtl/adq_cell.sv
// ----------------------------------------------------------------------------
// adq_cell
// One storage word of the deque; shifts to or from its neighbours and
// offers its word on the read tap when addressed.
// ----------------------------------------------------------------------------
module adq_cell import adq_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDef,
  parameter int unsigned CntBits  = 7,
  parameter int unsigned IdxBits  = 6,
  parameter int unsigned Index    = 0
) (
  input  logic                clk_i,
  input  cell_ctl_t           ctl_i,
  input  logic [CntBits-1:0]  count_i,
  input  logic [IdxBits-1:0]  rd_idx_i,
  input  logic [WordBits-1:0] lower_i,
  input  logic [WordBits-1:0] upper_i,
  input  logic [WordBits-1:0] payload_i,
  output logic [WordBits-1:0] word_o,
  output logic [WordBits-1:0] tap_o
);

  logic [WordBits-1:0] word_q;
  logic [WordBits-1:0] word_d;
  logic                back_hit;
  logic                rd_hit;

  assign back_hit = (count_i == CntBits'(Index));
  assign rd_hit   = (rd_idx_i == IdxBits'(Index));

  // Take from below, from above, or load the new back item
  always_comb begin
    if (ctl_i.ins_front) begin
      word_d = lower_i;
    end else if (ctl_i.rem_front) begin
      word_d = upper_i;
    end else if (ctl_i.ins_back && back_hit) begin
      word_d = payload_i;
    end else begin
      word_d = word_q;
    end
  end

  // Hold the word; no reset on payload
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign tap_o  = word_q & {WordBits{rd_hit}};

endmodule

// File: rtl/array_deque_with_indexed_read.sv
// The result of an accepted item is strobed on done_o in the cycle after it is accepted.
// One item is taken per cycle; busy is never raised, since every cell
// shifts in parallel and the read is one OR tree across the cell taps.
// Reset: the fill count and done_o clear asynchronously; cell contents are
// left undefined and are never read at or beyond the fill count.
// ----------------------------------------------------------------------------
// array_deque_with_indexed_read
// Double-ended queue held in a row of shifting cells, with indexed read.
// ----------------------------------------------------------------------------
module array_deque_with_indexed_read import adq_pkg::*; #(
  parameter int unsigned Depth    = DepthDef,
  parameter int unsigned WordBits = WordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [6:0]  position_i,
  input  logic [31:0] payload_i,
  output logic        done_o,
  output logic [31:0] element_o,
  output logic [1:0]  status_o,
  output logic [6:0]  fill_o
);

  `include "array_deque_with_indexed_read_assert.svh"

  localparam int unsigned CntBits = $clog2(Depth + 1);
  localparam int unsigned IdxBits = $clog2(Depth);
  localparam int unsigned CmpBits = (CntBits > 7) ? CntBits : 7;

  logic [CntBits-1:0]  count_q;
  logic [CntBits-1:0]  count_d;
  logic                done_q;
  logic [31:0]         element_q;
  logic [1:0]          status_q;
  logic [6:0]          fill_q;

  logic                accept;
  logic                full;
  logic                empty;
  logic                pos_ok;
  logic [CmpBits-1:0]  pos_ext;
  logic [1:0]          status_d;
  logic                want_elem;
  logic [IdxBits-1:0]  rd_idx;
  logic [WordBits-1:0] data_w;
  logic [WordBits-1:0] rd_word;
  logic [31:0]         element_d;
  cell_ctl_t           ctl;

  logic [WordBits-1:0] words [Depth];
  logic [WordBits-1:0] taps  [Depth];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign full    = (count_q == CntBits'(Depth));
  assign empty   = (count_q == '0);
  assign pos_ext = CmpBits'(position_i);
  assign pos_ok  = (position_i != '0) && (pos_ext <= CmpBits'(count_q));
  assign data_w  = WordBits'(payload_i);

  // Decode the request into status, cell commands and read address
  always_comb begin
    status_d      = ST_OK;
    want_elem     = 1'b0;
    rd_idx        = '0;
    ctl           = '0;
    count_d       = count_q;
    unique case (kind_i)
      KIND_READ: begin
        rd_idx = IdxBits'(pos_ext - CmpBits'(1));
        if (pos_ok) begin
          want_elem = 1'b1;
        end else begin
          status_d = ST_RANGE;
        end
      end
      KIND_INS_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctl.ins_front = 1'b1;
          count_d       = count_q + CntBits'(1);
        end
      end
      KIND_INS_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctl.ins_back = 1'b1;
          count_d      = count_q + CntBits'(1);
        end
      end
      KIND_REM_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          want_elem     = 1'b1;
          ctl.rem_front = 1'b1;
          count_d       = count_q - CntBits'(1);
        end
      end
      KIND_REM_BACK: begin
        rd_idx = IdxBits'(count_q - CntBits'(1));
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          want_elem = 1'b1;
          count_d   = count_q - CntBits'(1);
        end
      end
      default: begin
      end
    endcase
    // Drop every command unless an item is accepted
    if (!accept) begin
      ctl     = '0;
      count_d = count_q;
    end
  end

  // Row of cells, each fed by its neighbours
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [WordBits-1:0] lower;
    logic [WordBits-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = data_w;
    end else begin : g_lower
      assign lower = words[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = words[i+1];
    end
    adq_cell #(
      .WordBits (WordBits),
      .CntBits  (CntBits),
      .IdxBits  (IdxBits),
      .Index    (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .count_i   (count_q),
      .rd_idx_i  (rd_idx),
      .lower_i   (lower),
      .upper_i   (upper),
      .payload_i (data_w),
      .word_o    (words[i]),
      .tap_o     (taps[i])
    );
  end

  // Gather the addressed word from the cell taps
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < Depth; i++) begin
      rd_word = rd_word | taps[i];
    end
  end

  assign element_d = want_elem ? 32'(rd_word) : 32'd0;

  // Hold the fill count and the strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // Register the result item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      element_q <= element_d;
      status_q  <= status_d;
      fill_q    <= 7'(count_d);
    end
  end

  assign done_o    = done_q;
  assign element_o = element_q;
  assign status_o  = status_q;
  assign fill_o    = fill_q;

  `ADQ_ASSERT_ALWAYS(a_count_bound, count_q <= CntBits'(Depth))
  `ADQ_ASSERT_NEXT(a_done_follows, accept, done_o)
  `ADQ_ASSERT_NEXT(a_fill_matches, accept, fill_o == 7'(count_q))
  `ADQ_ASSERT_NEXT(a_ins_grows, accept && kind_i == KIND_INS_BACK && !full,
                   count_q == $past(count_q) + CntBits'(1))

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Deque block testbench
// Drives read, insert and remove requests into the shifting-cell deque and
// checks every strobed result against a behavioural copy of the cell row.
// A short directed opening covers the edge cases, then random traffic runs
// in fill, drain and mixed phases so that the store reaches full and empty.
// ----------------------------------------------------------------------------
module testbench import adq_pkg::*;;

  localparam int unsigned Depth       = DepthDef;
  localparam int unsigned RandomItems = 1330;
  localparam int unsigned QuietTail   = 150;

  // Kind codes the block treats as no operation
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [31:0] element;
    logic [1:0]  status;
    logic [6:0]  fill;
  } deque_result_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_e;

  // Track the cell row and the results still owed by the block
  class deque_tracker;
    logic [31:0]   word_store [Depth];
    int unsigned   fill_level;
    deque_result_t owed_results [$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    int unsigned   full_hits;
    int unsigned   empty_hits;
    int unsigned   range_hits;

    function new();
      fill_level   = 0;
      mismatches   = 0;
      results_seen = 0;
      full_hits    = 0;
      empty_hits   = 0;
      range_hits   = 0;
    endfunction

    function int unsigned owed();
      return owed_results.size();
    endfunction

    // Apply one accepted item to the cell row and queue its result
    function void note_request(logic [2:0] kind, logic [6:0] pos, logic [31:0] word);
      deque_result_t res;
      int unsigned   i;
      res.element = '0;
      res.status  = ST_OK;
      case (kind)
        KIND_READ: begin
          if (pos >= 1 && pos <= fill_level) begin
            res.element = word_store[pos - 1];
          end else begin
            res.status = ST_RANGE;
            range_hits++;
          end
        end
        KIND_INS_FRONT: begin
          if (fill_level >= Depth) begin
            res.status = ST_FULL;
            full_hits++;
          end else begin
            for (i = fill_level; i > 0; i--) word_store[i] = word_store[i - 1];
            word_store[0] = word;
            fill_level++;
          end
        end
        KIND_INS_BACK: begin
          if (fill_level >= Depth) begin
            res.status = ST_FULL;
            full_hits++;
          end else begin
            word_store[fill_level] = word;
            fill_level++;
          end
        end
        KIND_REM_FRONT: begin
          if (fill_level == 0) begin
            res.status = ST_EMPTY;
            empty_hits++;
          end else begin
            res.element = word_store[0];
            for (i = 0; i + 1 < fill_level; i++) word_store[i] = word_store[i + 1];
            fill_level--;
          end
        end
        KIND_REM_BACK: begin
          if (fill_level == 0) begin
            res.status = ST_EMPTY;
            empty_hits++;
          end else begin
            fill_level--;
            res.element = word_store[fill_level];
          end
        end
        default: begin
        end
      endcase
      res.fill = fill_level[6:0];
      owed_results.push_back(res);
    endfunction

    // Compare a strobed result with the oldest one owed
    function void check_result(logic [31:0] element, logic [1:0] status, logic [6:0] fill);
      deque_result_t want;
      results_seen++;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result: element %h status %0d fill %0d",
                 $time, element, status, fill);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      if (element !== want.element) begin
        $display("%0t: element mismatch: expected %h actual %h", $time, want.element, element);
        mismatches++;
      end
      if (status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, status);
        mismatches++;
      end
      if (fill !== want.fill) begin
        $display("%0t: fill mismatch: expected %0d actual %0d", $time, want.fill, fill);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni     = 1'b0;
  logic        start      = 1'b0;
  logic        busy;
  logic [2:0]  kind_i     = KIND_READ;
  logic [6:0]  position_i = '0;
  logic [31:0] payload_i  = '0;
  logic        done_o;
  logic [31:0] element_o;
  logic [1:0]  status_o;
  logic [6:0]  fill_o;

  deque_tracker tracker;

  array_deque_with_indexed_read dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .kind_i     (kind_i),
    .position_i (position_i),
    .payload_i  (payload_i),
    .done_o     (done_o),
    .element_o  (element_o),
    .status_o   (status_o),
    .fill_o     (fill_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Check every strobed result
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      tracker.check_result(element_o, status_o, fill_o);
    end
  end

  // Present one item and hold it until the block takes it
  task automatic send_item(input logic [2:0] kind, input logic [6:0] pos,
                           input logic [31:0] word);
    start      <= 1'b1;
    kind_i     <= kind;
    position_i <= pos;
    payload_i  <= word;
    do @(posedge clk_i); while (busy);
    tracker.note_request(kind, pos, word);
  endtask

  // Drop start for a few cycles
  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off until every owed result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.owed() != 0);
  endtask

  // Pick and send one random item, biased by the traffic phase
  task automatic random_item(input traffic_mode_e mode);
    int unsigned roll;
    int unsigned insert_share;
    logic [2:0]  kind;
    logic [6:0]  pos;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  insert_share = 85;
      MODE_DRAIN: insert_share = 15;
      default:    insert_share = 50;
    endcase
    if (roll < 3) begin
      kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    end else if (roll < 20) begin
      kind = KIND_READ;
    end else if ($urandom_range(0, 99) < insert_share) begin
      kind = $urandom_range(0, 1) ? KIND_INS_FRONT : KIND_INS_BACK;
    end else begin
      kind = $urandom_range(0, 1) ? KIND_REM_FRONT : KIND_REM_BACK;
    end
    // Aim most reads inside the fill, the rest anywhere in the field
    if (kind == KIND_READ && tracker.fill_level > 0 && $urandom_range(0, 3) != 0) begin
      pos = 7'($urandom_range(1, tracker.fill_level));
    end else begin
      pos = 7'($urandom_range(0, 127));
    end
    send_item(kind, pos, $urandom());
  endtask

  // Stimulus
  initial begin
    int unsigned   sent;
    int unsigned   seg;
    int unsigned   seg_len;
    int unsigned   j;
    int unsigned   guard;
    bit            idling;
    traffic_mode_e mode;

    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: empty store, range edges, spare kinds, both ends
    send_item(KIND_REM_FRONT, 7'd0, 32'h0);
    send_item(KIND_REM_BACK, 7'd0, 32'hFFFF_FFFF);
    send_item(KIND_READ, 7'd1, $urandom());
    send_item(KIND_READ, 7'd0, $urandom());
    send_item(KIND_INS_BACK, 7'd127, 32'hFFFF_FFFF);
    send_item(KIND_INS_FRONT, 7'd0, 32'h0000_0000);
    send_item(KIND_READ, 7'd0, $urandom());
    send_item(KIND_READ, 7'd1, $urandom());
    send_item(KIND_READ, 7'd2, $urandom());
    send_item(KIND_READ, 7'd3, $urandom());
    send_item(KIND_READ, 7'd127, $urandom());
    send_item(KIND_READ, 7'd64, $urandom());
    send_item(KIND_SPARE_FIRST, 7'd1, 32'hDEAD_BEEF);
    send_item(KIND_SPARE_FIRST + 3'd1, 7'd2, 32'hFFFF_FFFF);
    send_item(KIND_SPARE_LAST, 7'd127, 32'h1234_5678);
    send_item(KIND_INS_BACK, 7'd0, 32'hA5A5_A5A5);
    send_item(KIND_REM_FRONT, 7'd0, $urandom());
    send_item(KIND_REM_BACK, 7'd0, $urandom());
    send_item(KIND_REM_BACK, 7'd0, $urandom());
    send_item(KIND_REM_FRONT, 7'd0, $urandom());
    wait_drained();

    // Random traffic in alternating fill, drain and mixed phases
    sent = 0;
    seg  = 0;
    while (sent < RandomItems) begin
      mode    = traffic_mode_e'(seg % 3);
      seg_len = $urandom_range(80, 160);
      idling  = ($urandom_range(0, 2) != 0);
      for (j = 0; j < seg_len && sent < RandomItems; j++) begin
        random_item(mode);
        sent++;
        if (idling && sent < RandomItems - QuietTail && $urandom_range(0, 3) == 0) begin
          idle_cycles($urandom_range(1, 3));
        end
      end
      if (seg % 4 == 1 && sent < RandomItems - QuietTail) begin
        wait_drained();
      end
      seg++;
    end

    // Let the last results arrive
    start <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (tracker.owed() != 0 && guard < 1000);
    repeat (4) @(posedge clk_i);
    if (tracker.owed() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.owed());
      tracker.mismatches += tracker.owed();
    end

    $display("Checked %0d results from %0d random and directed items over %0d phases.",
             tracker.results_seen, sent + 20, seg);
    $display("Full rejects %0d, empty removals %0d, out-of-range reads %0d.",
             tracker.full_hits, tracker.empty_hits, tracker.range_hits);
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("Timed out waiting for the block");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
